// File: hw/rtl/pipv_pkg.sv
// Shared types, constants and sizes for the pulsed IR frame peak/valley detector.
// Used by every module of the block; depends on nothing.
package pipv_pkg;

    localparam int MAX_FRAME_SAMPLES = 4096;
    localparam int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int POS_W             = $clog2(MAX_FRAME_SAMPLES);

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    // Rate times on-time, and frame positions scaled by 10^6, for the on-window checks.
    localparam int PROD_W    = 2 * CFG_W;
    // Amplitude times gain, and that product times the reciprocal of 1000.
    localparam int GPROD_W   = 2 * SAMPLE_W;
    localparam int RECIP_W   = 29;
    localparam int RECIP_SH  = 38;
    localparam int COMP_W    = GPROD_W + RECIP_W;
    // ceil(2^38 / 1000); the shifted product is the exact quotient for any 32-bit operand.
    localparam logic [RECIP_W-1:0] MILLI_RECIP = RECIP_W'(274877907);

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 20;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [DIV_DEN_W-1:0] US_PER_S = DIV_DEN_W'(1000000);
    localparam logic [DIV_DEN_W-1:0] MILLI    = DIV_DEN_W'(1000);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_PARAM    = 3'd1,
        ST_SATURATED    = 3'd2,
        ST_OUT_OF_PHASE = 3'd3,
        ST_BAD_CAL      = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE    = 3'd0,
        CFG_ON_TIME = 3'd1,
        CFG_PERIOD  = 3'd2,
        CFG_SAT_LIM = 3'd3,
        CFG_GAIN    = 3'd4,
        CFG_REF     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]    rate;
        logic [CFG_W-1:0]    on_time;
        logic [CFG_W-1:0]    period;
        logic [SAMPLE_W-1:0] sat_lim;
        logic [SAMPLE_W-1:0] gain;
        logic [SAMPLE_W-1:0] ref_level;
    } t_cfg;

    // Summary of one finished frame, handed from the front to the back.
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] valley;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    len;
        logic                ovf;
    } t_frame;

    // Result item; status sits in the lowest bits.
    typedef struct packed {
        logic [SAMPLE_W-1:0] ratio;
        logic [SAMPLE_W-1:0] comp;
        logic [SAMPLE_W-1:0] amp;
        logic [SAMPLE_W-1:0] valley;
        logic [SAMPLE_W-1:0] peak;
        t_status             status;
    } t_result;

endpackage

// File: hw/rtl/pipv_front.sv
// Front end: accepts samples and tracks peak, first peak index, valley and length.
// Pushes a frame summary into the queue on the last sample. Depends on pipv_pkg.
module pipv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [pipv_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output pipv_pkg::t_frame              o_frame
);

    logic [pipv_pkg::SAMPLE_W-1:0] r_peak,   n_peak;
    logic [pipv_pkg::SAMPLE_W-1:0] r_valley, n_valley;
    logic [pipv_pkg::POS_W-1:0]    r_pos,    n_pos;
    logic [pipv_pkg::CNT_W-1:0]    r_cnt,    n_cnt;
    logic                          r_ovf,    n_ovf;
    logic                          accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_peak   = r_peak;
        n_valley = r_valley;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        if (r_cnt >= pipv_pkg::CNT_W'(pipv_pkg::MAX_FRAME_SAMPLES)) begin
            n_ovf = 1'b1;
        end else begin
            if (r_cnt == '0) begin
                n_peak   = i_sample;
                n_valley = i_sample;
                n_pos    = '0;
            end else begin
                if (i_sample > r_peak) begin
                    n_peak = i_sample;
                    n_pos  = r_cnt[pipv_pkg::POS_W-1:0];
                end
                if (i_sample < r_valley) begin
                    n_valley = i_sample;
                end
            end
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_push         = accept && i_last;
    assign o_frame.peak   = n_peak;
    assign o_frame.valley = n_valley;
    assign o_frame.pos    = n_pos;
    assign o_frame.len    = n_cnt;
    assign o_frame.ovf    = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_peak   <= n_peak;
            r_valley <= n_valley;
            r_pos    <= n_pos;
        end
    end

endmodule

// File: hw/rtl/pipv_fifo.sv
// Short queue of frame summaries between the front end and the back end.
// Depends on pipv_pkg for its depth and entry type.
module pipv_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pipv_pkg::t_frame i_data,
    input  logic             i_pop,
    output pipv_pkg::t_frame o_data,
    output logic             o_full,
    output logic             o_empty
);

    pipv_pkg::t_frame                r_mem [pipv_pkg::FIFO_DEPTH];
    logic [pipv_pkg::FIFO_PTR_W-1:0] r_wptr;
    logic [pipv_pkg::FIFO_PTR_W-1:0] r_rptr;
    logic [pipv_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_cnt == pipv_pkg::FIFO_CNT_W'(pipv_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == pipv_pkg::FIFO_PTR_W'(pipv_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == pipv_pkg::FIFO_PTR_W'(pipv_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/pipv_div.sv
// Restoring divider, one quotient bit per cycle, used by the back end.
// Depends on pipv_pkg for its operand widths.
module pipv_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pipv_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [pipv_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [pipv_pkg::DIV_NUM_W-1:0] o_quo
);

    logic [pipv_pkg::DIV_NUM_W-1:0] r_num;
    logic [pipv_pkg::DIV_DEN_W-1:0] r_rem;
    logic [pipv_pkg::DIV_DEN_W-1:0] r_den;
    logic [pipv_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [pipv_pkg::DIV_DEN_W:0]   trial;
    logic [pipv_pkg::DIV_DEN_W:0]   diff;
    logic                           ge;

    assign trial  = {r_rem, r_num[pipv_pkg::DIV_NUM_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign diff   = trial - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pipv_pkg::DIV_CNT_W'(pipv_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[pipv_pkg::DIV_NUM_W-2:0], ge};
            r_rem <= ge ? diff[pipv_pkg::DIV_DEN_W-1:0] : trial[pipv_pkg::DIV_DEN_W-1:0];
        end
    end

endmodule

// File: hw/rtl/pipv_back.sv
// Back end: per frame summary, checks the on-window with constant products; for a good frame,
// compensates the amplitude by a reciprocal multiply and forms the ratio with the divider, and
// holds the result. Depends on pipv_pkg, pipv_div.
module pipv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pipv_pkg::t_cfg   i_cfg,
    input  pipv_pkg::t_frame i_frame,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output pipv_pkg::t_result o_result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ON    = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_COMP  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_RATIO = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                         r_state, n_state;
    pipv_pkg::t_frame               r_frame;
    logic [pipv_pkg::PROD_W-1:0]    r_on_prod;
    logic [pipv_pkg::PROD_W-1:0]    r_len_lim;
    logic [pipv_pkg::PROD_W-1:0]    r_pos_lim;
    logic [pipv_pkg::GPROD_W-1:0]   r_gprod;
    pipv_pkg::t_status              r_status, n_status;
    logic [pipv_pkg::SAMPLE_W-1:0]  r_comp;
    logic [pipv_pkg::SAMPLE_W-1:0]  r_ratio;
    logic                           r_valid;
    pipv_pkg::t_result              r_result;

    logic                           div_start;
    logic [pipv_pkg::DIV_NUM_W-1:0] div_num;
    logic [pipv_pkg::DIV_DEN_W-1:0] div_den;
    logic                           div_done;
    logic [pipv_pkg::DIV_NUM_W-1:0] div_quo;
    logic [pipv_pkg::SAMPLE_W-1:0]  quo_sat;
    logic [pipv_pkg::COMP_W-1:0]    comp_full;
    logic [pipv_pkg::SAMPLE_W-1:0]  comp_sat;
    logic [pipv_pkg::SAMPLE_W-1:0]  amp;
    logic                           out_free;
    logic                           bad_param;

    pipv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // The divider only forms the ratio to the reference level.
    assign div_start = (r_state == S_DIV);
    assign div_num   = pipv_pkg::DIV_NUM_W'(r_comp) * pipv_pkg::DIV_NUM_W'(pipv_pkg::MILLI);
    assign div_den   = pipv_pkg::DIV_DEN_W'(i_cfg.ref_level);

    assign quo_sat  = (div_quo > pipv_pkg::DIV_NUM_W'(16'hFFFF))
                      ? '1 : div_quo[pipv_pkg::SAMPLE_W-1:0];

    // Division by 1000 as a multiply by the scaled reciprocal and a shift, then saturation.
    assign comp_full = pipv_pkg::COMP_W'(r_gprod) * pipv_pkg::COMP_W'(pipv_pkg::MILLI_RECIP);
    assign comp_sat  = (|comp_full[pipv_pkg::COMP_W-1:pipv_pkg::RECIP_SH+pipv_pkg::SAMPLE_W])
                       ? '1
                       : comp_full[pipv_pkg::RECIP_SH+pipv_pkg::SAMPLE_W-1:pipv_pkg::RECIP_SH];

    assign amp      = r_frame.peak - r_frame.valley;
    assign out_free = !r_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The checks run in the order of precedence of the status codes. The on-window is the
    // product of rate and on-time over 10^6: it is empty when the product is below 10^6,
    // it reaches the frame length when the product reaches length * 10^6, and the first peak
    // lies outside it when the product is below (index + 1) * 10^6.
    always_comb begin
        bad_param = r_frame.ovf
                 || (i_cfg.rate == '0)
                 || (i_cfg.on_time == '0)
                 || (i_cfg.on_time >= i_cfg.period)
                 || (r_on_prod < pipv_pkg::PROD_W'(pipv_pkg::US_PER_S))
                 || (r_on_prod >= r_len_lim);
        if (bad_param) begin
            n_status = pipv_pkg::ST_BAD_PARAM;
        end else if ((i_cfg.sat_lim != '0) && (r_frame.peak >= i_cfg.sat_lim)) begin
            n_status = pipv_pkg::ST_SATURATED;
        end else if (r_on_prod < r_pos_lim) begin
            n_status = pipv_pkg::ST_OUT_OF_PHASE;
        end else if ((i_cfg.gain == '0) || (i_cfg.ref_level == '0)) begin
            n_status = pipv_pkg::ST_BAD_CAL;
        end else begin
            n_status = pipv_pkg::ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_ON;
                end
            end
            S_ON: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (n_status == pipv_pkg::ST_OK) begin
                    n_state = S_COMP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_COMP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_RATIO;
            end
            S_RATIO: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
        if (r_state == S_ON) begin
            r_on_prod <= pipv_pkg::PROD_W'(i_cfg.rate) * pipv_pkg::PROD_W'(i_cfg.on_time);
            r_len_lim <= pipv_pkg::PROD_W'(r_frame.len)
                       * pipv_pkg::PROD_W'(pipv_pkg::US_PER_S);
            r_pos_lim <= (pipv_pkg::PROD_W'(r_frame.pos) + pipv_pkg::PROD_W'(1))
                       * pipv_pkg::PROD_W'(pipv_pkg::US_PER_S);
        end
        if (r_state == S_CHECK) begin
            r_status <= n_status;
            r_comp   <= '0;
            r_ratio  <= '0;
            r_gprod  <= pipv_pkg::GPROD_W'(amp) * pipv_pkg::GPROD_W'(i_cfg.gain);
        end
        if (r_state == S_COMP) begin
            r_comp <= comp_sat;
        end
        if ((r_state == S_RATIO) && div_done) begin
            r_ratio <= quo_sat;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_result.status <= r_status;
            r_result.comp   <= r_comp;
            r_result.ratio  <= r_ratio;
            if ((r_status == pipv_pkg::ST_OK) || (r_status == pipv_pkg::ST_BAD_CAL)) begin
                r_result.peak   <= r_frame.peak;
                r_result.valley <= r_frame.valley;
                r_result.amp    <= amp;
            end else begin
                r_result.peak   <= '0;
                r_result.valley <= '0;
                r_result.amp    <= '0;
            end
        end
    end

endmodule

// File: hw/rtl/pulsed_ir_frame_peak_valley.sv
// Top level of the pulsed IR frame peak/valley detector: configuration registers,
// front end, frame queue and back end. Depends on pipv_pkg, pipv_front, pipv_fifo, pipv_back.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    tdata = sample, tlast = last_sample
//   m_axis    out        m_axis_tvalid/m_axis_tready    tdata = status .. ratio_x1000
//   cfg       in         i_cfg_we (no wait)             i_cfg_addr, i_cfg_wdata
//
// The front end takes one sample per cycle while the queue has room; its compare and count
// are combinational. Each finished frame then passes the back end states idle, on, check and
// out when it ends in an error status, and also comp, div and ratio when it is good, the ratio
// state waiting on the bit-serial divider. The on-window checks compare products against
// constant multiples of 10^6 and the gain compensation is a reciprocal multiply, so only the
// ratio needs the divider. A two-entry queue of frame summaries lets the front end keep taking
// samples while the back end works; the front end stalls only when both entries are taken.
// Reset is synchronous, active low, and needs no clearing pass. A result waits in the output
// register while the back end starts on the next frame; the back end stalls only when it has a
// second result ready and the first has not been taken.
module pulsed_ir_frame_peak_valley (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [15:0] sample
    input  logic                           s_axis_tlast,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [87:0]                    m_axis_tdata,  // [2:0] status, [18:3] peak,
                                                          // [34:19] valley, [50:35] amplitude,
                                                          // [66:51] compensated,
                                                          // [82:67] ratio_x1000, rest zero
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [pipv_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [pipv_pkg::CFG_W-1:0]     i_cfg_wdata
);

    pipv_pkg::t_cfg    r_cfg;
    pipv_pkg::t_frame  front_frame;
    pipv_pkg::t_frame  fifo_frame;
    pipv_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    // Configuration registers. Writes to an index beyond the list are dropped. The
    // 16-bit registers keep the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate      <= '0;
            r_cfg.on_time   <= '0;
            r_cfg.period    <= '0;
            r_cfg.sat_lim   <= '0;
            r_cfg.gain      <= pipv_pkg::SAMPLE_W'(1000);
            r_cfg.ref_level <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pipv_pkg::CFG_RATE:    r_cfg.rate      <= i_cfg_wdata;
                pipv_pkg::CFG_ON_TIME: r_cfg.on_time   <= i_cfg_wdata;
                pipv_pkg::CFG_PERIOD:  r_cfg.period    <= i_cfg_wdata;
                pipv_pkg::CFG_SAT_LIM: r_cfg.sat_lim   <= i_cfg_wdata[pipv_pkg::SAMPLE_W-1:0];
                pipv_pkg::CFG_GAIN:    r_cfg.gain      <= i_cfg_wdata[pipv_pkg::SAMPLE_W-1:0];
                pipv_pkg::CFG_REF:     r_cfg.ref_level <= i_cfg_wdata[pipv_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: per-sample tracking of peak, first peak index, valley and length.
    pipv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_full   (full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_frame  (front_frame)
    );

    // Queue of finished frame summaries.
    pipv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_frame),
        .i_pop   (pop),
        .o_data  (fifo_frame),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back end: status decision, gain compensation and ratio, output register.
    pipv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_frame  (fifo_frame),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (result)
    );

    assign m_axis_tdata = {5'b0, result};

endmodule
